@@ rtl/readahead_buffer_cache_top_assert.svh @@
// assertion macros for the read-ahead buffer cache
// used by rbc_dp; no other dependencies
`ifndef READAHEAD_BUFFER_CACHE_TOP_ASSERT_SVH
`define READAHEAD_BUFFER_CACHE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RBC_ASSERT(lbl, prop, msg)
`define RBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/rbc_pkg.sv @@
// package for the read-ahead buffer cache: payload structs, codes,
// controller/datapath command and status structs; no dependencies
package rbc_pkg;

  localparam int unsigned BuffersDefault = 8;
  localparam int unsigned OffW = 48;
  localparam int unsigned LenW = 21;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_FLUSH  = 2'd1;
  localparam logic [1:0] CMD_FILL   = 2'd2;

  localparam logic [2:0] ST_HIT  = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [20:0] BufSizeReset = 21'd65536;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] file_handle;
    logic [31:0] fs_id;
    logic [47:0] byte_offset;
    logic [20:0] request_length;
    logic        speculative;
    logic [2:0]  buffer_id;
    logic [20:0] filled_bytes;
  } rbc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  buffer_index;
    logic [47:0] block_offset;
    logic [20:0] amount_ready;
  } rbc_out_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic flush_step;
    logic exec;
    logic out_load;
  } rbc_cmd_t;

  typedef struct packed {
    logic is_scan;
    logic is_flush;
    logic scan_last;
    logic found;
    logic div_done;
  } rbc_stat_t;

endpackage

@@ rtl/rbc_ctrl.sv @@
// controller state machine for the read-ahead buffer cache
// depends on rbc_pkg command and status structs
module rbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  rbc_pkg::rbc_stat_t stat_i,
  output rbc_pkg::rbc_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DIV   = 6'b000100,
    S_FLUSH = 6'b001000,
    S_EXEC  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat_i.is_scan) begin
          state_d = S_EXEC;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.scan_last) begin
            if (stat_i.is_flush) state_d = S_FLUSH;
            else if (stat_i.found) state_d = S_EXEC;
            else state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_EXEC;
      end
      S_FLUSH: begin
        // same step counter, one rank per cycle
        cmd_o.flush_step = 1'b1;
        if (stat_i.scan_last) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/rbc_dp.sv @@
// datapath of the read-ahead buffer cache: entry table, free fifo,
// serial tag scan, bit-serial offset remainder; depends on rbc_pkg
`include "readahead_buffer_cache_top_assert.svh"
module rbc_dp #(
  parameter int unsigned BUFFERS = rbc_pkg::BuffersDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbc_pkg::rbc_in_t   in_data_i,
  input  logic               cfg_we_i,
  input  logic [20:0]        cfg_data_i,
  input  rbc_pkg::rbc_cmd_t  cmd_i,
  output rbc_pkg::rbc_stat_t stat_o,
  output rbc_pkg::rbc_out_t  out_data_o
);

  localparam int unsigned IW = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam int unsigned CW = $clog2(BUFFERS + 1);
  localparam int unsigned OW = rbc_pkg::OffW;
  localparam int unsigned LW = rbc_pkg::LenW;

  rbc_pkg::rbc_in_t  item_q;
  rbc_pkg::rbc_out_t res_q, res_d, out_q;
  logic [LW-1:0]     cfg_q;

  logic [BUFFERS-1:0] use_q, use_d, val_q, val_d, frd_q, frd_d, mask_q, mask_d;
  logic [63:0]   tagh_q [BUFFERS];
  logic [31:0]   tagf_q [BUFFERS];
  logic [OW-1:0] tago_q [BUFFERS], tago_d [BUFFERS];
  logic [LW-1:0] data_q [BUFFERS], data_d [BUFFERS];
  logic [7:0]    wait_q [BUFFERS], wait_d [BUFFERS];
  logic [IW-1:0] lru_q  [BUFFERS], lru_d  [BUFFERS];
  logic [IW-1:0] age_q  [BUFFERS], age_d  [BUFFERS];
  logic [IW-1:0] fifo_q [BUFFERS], fifo_d [BUFFERS];
  logic [CW-1:0] fcnt_q, fcnt_d, ucnt_q, ucnt_d;
  logic          tag_we;

  logic [IW-1:0] step_q, kcnt_q, best_q;
  logic          found_q;
  logic [LW-1:0] rem_q;
  logic [5:0]    dcnt_q;

  logic [BUFFERS-1:0] fl_hit;
  logic [IW-1:0]      fl_tgt, fl_b;

  logic [LW-1:0] bs;
  assign bs = (cfg_q == '0) ? LW'(1) : cfg_q;

  // serial scan of one entry per cycle
  logic          own_i, cov_i, scan_last;
  logic [OW:0]   req_end, buf_end;
  assign own_i = use_q[step_q] && (tagh_q[step_q] == item_q.file_handle)
                 && (tagf_q[step_q] == item_q.fs_id);
  assign req_end = {1'b0, item_q.byte_offset} + (OW+1)'(item_q.request_length);
  assign buf_end = {1'b0, tago_q[step_q]} + (OW+1)'(bs);
  assign cov_i = (item_q.byte_offset >= tago_q[step_q]) && (req_end <= buf_end);
  assign scan_last = (step_q == IW'(BUFFERS - 1));

  // restoring remainder, one offset bit a cycle
  logic [LW:0] rem_sh;
  assign rem_sh = {rem_q, item_q.byte_offset[dcnt_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= rbc_pkg::BufSizeReset;
      step_q  <= '0;
      kcnt_q  <= '0;
      found_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (cmd_i.load) begin
        step_q  <= '0;
        kcnt_q  <= '0;
        found_q <= 1'b0;
        dcnt_q  <= 6'(OW - 1);
      end else begin
        if (cmd_i.scan_step || cmd_i.flush_step)
          step_q <= scan_last ? '0 : step_q + IW'(1);
        if (cmd_i.scan_step && own_i && cov_i &&
            (!found_q || age_q[step_q] < age_q[best_q]))
          found_q <= 1'b1;
        if (cmd_i.flush_step && (|fl_hit)) kcnt_q <= kcnt_q + IW'(1);
        if (dcnt_q != '0) dcnt_q <= dcnt_q - 6'd1;
      end
    end
  end

  logic div_run_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_run_q <= 1'b0;
    else if (cmd_i.load) div_run_q <= 1'b1;
    else if (dcnt_q == '0) div_run_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      rem_q  <= '0;
    end else if (div_run_q) begin
      rem_q <= (rem_sh >= {1'b0, bs}) ? LW'(rem_sh - {1'b0, bs}) : rem_sh[LW-1:0];
    end
    if (cmd_i.scan_step && own_i && cov_i && (!found_q || age_q[step_q] < age_q[best_q]))
      best_q <= step_q;
    if (cmd_i.exec) res_q <= res_d;
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign stat_o.is_scan   = (item_q.command == rbc_pkg::CMD_LOOKUP) ||
                            (item_q.command == rbc_pkg::CMD_FLUSH);
  assign stat_o.is_flush  = (item_q.command == rbc_pkg::CMD_FLUSH);
  assign stat_o.scan_last = scan_last;
  assign stat_o.found     = found_q || (own_i && cov_i);
  assign stat_o.div_done  = !div_run_q;
  assign out_data_o       = out_q;

  // flush: entry whose current rank is its original rank less those done
  assign fl_tgt = step_q - kcnt_q;
  always_comb begin
    fl_b = '0;
    for (int j = 0; j < BUFFERS; j++) begin
      fl_hit[j] = mask_q[j] && use_q[j] && (age_q[j] == fl_tgt);
      if (fl_hit[j]) fl_b = IW'(j);
    end
  end

  logic [IW-1:0] bidx, hb, tb;
  logic          bid_ok, hfound;
  assign bidx   = IW'(item_q.buffer_id);
  assign bid_ok = (32'(item_q.buffer_id) < BUFFERS);

  always_comb begin
    logic [OW:0] e_end, e_dif, e_amt;
    use_d  = use_q;  val_d  = val_q;  frd_d  = frd_q;  mask_d = mask_q;
    fcnt_d = fcnt_q; ucnt_d = ucnt_q;
    tago_d = tago_q; data_d = data_q; wait_d = wait_q;
    lru_d  = lru_q;  age_d  = age_q;  fifo_d = fifo_q;
    tag_we = 1'b0;
    tb     = '0;
    res_d  = '0;
    res_d.status = rbc_pkg::ST_NONE;
    e_end = '0; e_dif = '0; e_amt = '0;
    hb = '0; hfound = 1'b0;
    for (int j = 0; j < BUFFERS; j++)
      if (use_q[j] && lru_q[j] == '0) begin
        hb = IW'(j); hfound = 1'b1;
      end

    if (cmd_i.load) mask_d = '0;
    if (cmd_i.scan_step && own_i) mask_d[step_q] = 1'b1;

    if (cmd_i.flush_step && (|fl_hit)) begin
      for (int j = 0; j < BUFFERS; j++)
        if (IW'(j) != fl_b && use_q[j]) begin
          if (lru_q[j] > lru_q[fl_b]) lru_d[j] = lru_q[j] - IW'(1);
          if (age_q[j] > age_q[fl_b]) age_d[j] = age_q[j] - IW'(1);
        end
      use_d[fl_b] = 1'b0;
      ucnt_d = ucnt_q - CW'(1);
      if (!val_q[fl_b] || wait_q[fl_b] != '0) begin
        frd_d[fl_b] = 1'b1;
      end else begin
        val_d[fl_b] = 1'b0; frd_d[fl_b] = 1'b0; data_d[fl_b] = '0;
        wait_d[fl_b] = '0; lru_d[fl_b] = '0; age_d[fl_b] = '0;
        if (fcnt_q < CW'(BUFFERS)) begin
          fifo_d[fcnt_q[IW-1:0]] = fl_b;
          fcnt_d = fcnt_q + CW'(1);
        end
      end
    end

    if (cmd_i.exec) begin
      case (item_q.command)
        rbc_pkg::CMD_LOOKUP: begin
          if (found_q) begin
            for (int j = 0; j < BUFFERS; j++)
              if (IW'(j) != best_q && use_q[j] && lru_q[j] > lru_q[best_q])
                lru_d[j] = lru_q[j] - IW'(1);
            lru_d[best_q] = IW'(ucnt_q - CW'(1));
            res_d.buffer_index = 3'(best_q);
            res_d.block_offset = tago_q[best_q];
            if (val_q[best_q]) begin
              e_end = {1'b0, tago_q[best_q]} + (OW+1)'(data_q[best_q]);
              e_dif = e_end - {1'b0, item_q.byte_offset};
              e_amt = (e_end > {1'b0, item_q.byte_offset}) ? e_dif : '0;
              if (e_amt > (OW+1)'(item_q.request_length))
                e_amt = (OW+1)'(item_q.request_length);
              res_d.amount_ready = LW'(e_amt);
              res_d.status = rbc_pkg::ST_HIT;
            end else begin
              if (!item_q.speculative && wait_q[best_q] != 8'hff)
                wait_d[best_q] = wait_q[best_q] + 8'd1;
              res_d.status = rbc_pkg::ST_WAIT;
            end
          end else if (fcnt_q != '0 || hfound) begin
            if (fcnt_q != '0) begin
              tb = fifo_q[0];
              for (int j = 0; j < BUFFERS - 1; j++) fifo_d[j] = fifo_q[j+1];
              fcnt_d = fcnt_q - CW'(1);
              tag_we = 1'b1;
            end else begin
              tb = hb;
              for (int j = 0; j < BUFFERS; j++)
                if (IW'(j) != hb && use_q[j] && lru_q[j] > lru_q[hb])
                  lru_d[j] = lru_q[j] - IW'(1);
              if (wait_q[hb] != '0) begin
                // busy head goes to the tail and nothing is started
                lru_d[hb] = IW'(ucnt_q - CW'(1));
              end else begin
                for (int j = 0; j < BUFFERS; j++)
                  if (IW'(j) != hb && use_q[j] && age_q[j] > age_q[hb])
                    age_d[j] = age_q[j] - IW'(1);
                use_d[hb] = 1'b0;
                ucnt_d = ucnt_q - CW'(1);
                tag_we = 1'b1;
              end
            end
            if (tag_we) begin
              for (int j = 0; j < BUFFERS; j++)
                if (use_d[j]) age_d[j] = age_d[j] + IW'(1);
              val_d[tb] = 1'b0; frd_d[tb] = 1'b0; data_d[tb] = '0;
              age_d[tb] = '0;
              lru_d[tb] = IW'(ucnt_d);
              use_d[tb] = 1'b1;
              ucnt_d = ucnt_d + CW'(1);
              wait_d[tb] = 8'd1;
              tago_d[tb] = item_q.byte_offset - OW'(rem_q);
              res_d.status = rbc_pkg::ST_READ;
              res_d.buffer_index = 3'(tb);
              res_d.block_offset = item_q.byte_offset - OW'(rem_q);
            end
          end
        end
        rbc_pkg::CMD_FLUSH: res_d.status = rbc_pkg::ST_DONE;
        rbc_pkg::CMD_FILL: begin
          if (bid_ok && use_q[bidx]) begin
            val_d[bidx]  = 1'b1;
            data_d[bidx] = (item_q.filled_bytes > bs) ? bs : item_q.filled_bytes;
            wait_d[bidx] = '0;
            res_d.status = rbc_pkg::ST_DONE;
            res_d.buffer_index = item_q.buffer_id;
            res_d.block_offset = tago_q[bidx];
          end else if (bid_ok && frd_q[bidx]) begin
            val_d[bidx] = 1'b0; frd_d[bidx] = 1'b0; data_d[bidx] = '0;
            wait_d[bidx] = '0; lru_d[bidx] = '0; age_d[bidx] = '0;
            if (fcnt_q < CW'(BUFFERS)) begin
              fifo_d[fcnt_q[IW-1:0]] = bidx;
              fcnt_d = fcnt_q + CW'(1);
            end
            res_d.status = rbc_pkg::ST_DONE;
            res_d.buffer_index = item_q.buffer_id;
            res_d.block_offset = tago_q[bidx];
          end
        end
        default: res_d.status = rbc_pkg::ST_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q  <= '0;
      val_q  <= '0;
      frd_q  <= '0;
      mask_q <= '0;
      fcnt_q <= CW'(BUFFERS);
      ucnt_q <= '0;
      for (int j = 0; j < BUFFERS; j++) begin
        data_q[j] <= '0;
        wait_q[j] <= '0;
        lru_q[j]  <= '0;
        age_q[j]  <= '0;
        fifo_q[j] <= IW'(j);
      end
    end else begin
      use_q  <= use_d;
      val_q  <= val_d;
      frd_q  <= frd_d;
      mask_q <= mask_d;
      fcnt_q <= fcnt_d;
      ucnt_q <= ucnt_d;
      data_q <= data_d;
      wait_q <= wait_d;
      lru_q  <= lru_d;
      age_q  <= age_d;
      fifo_q <= fifo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tago_q <= tago_d;
    if (tag_we) begin
      tagh_q[tb] <= item_q.file_handle;
      tagf_q[tb] <= item_q.fs_id;
    end
  end

  `RBC_ASSERT(a_cnt_bound, ({1'b0, fcnt_q} + {1'b0, ucnt_q} <= (CW+1)'(BUFFERS)),
              "free and in-use counts exceed buffers")
  `RBC_ASSERT(a_use_freed, ((use_q & frd_q) == '0), "entry both in use and being freed")
  `RBC_ASSERT(a_ucnt, ($countones(use_q) == 32'(ucnt_q)), "in-use count out of step")

endmodule

@@ rtl/readahead_buffer_cache_top.sv @@
// top level of the read-ahead buffer cache
// instantiates rbc_ctrl and rbc_dp; types from rbc_pkg
//
// usage: one command beat on in_* (lookup, flush file, fill done) gives
// exactly one result beat on out_*. a beat moves when valid is high and
// stall is low. in_stall_o is high from acceptance until the result is
// placed in the output register, so one item is in flight at a time.
// a lookup hit or wait runs the serial scan (one tag per cycle), then
// executes; a lookup that misses also waits for the bit-serial
// remainder of the offset before it executes; a flush runs the scan,
// then one allocation rank per cycle; fill done and unknown commands
// skip the scan and go straight to execute.
// a result held by a stalled receiver does not block acceptance of the
// next item; that item's result waits in its own register until the
// output register frees up.
// cfg_* writes buf_size, accepted at any cycle (cfg_ready_o is tied
// high); write it only while the block is idle.
// reset: all buffers free, fifo holds 0 to BUFFERS-1, buf_size 65536.
module readahead_buffer_cache_top #(
  parameter int unsigned BUFFERS = rbc_pkg::BuffersDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rbc_pkg::rbc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rbc_pkg::rbc_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [20:0]      cfg_data_i
);

  rbc_pkg::rbc_cmd_t  cmd;
  rbc_pkg::rbc_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rbc_dp #(.BUFFERS(BUFFERS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
